>>> rtl/core/task_priority_queue_assert.svh
// Assertion macros for the task priority queue.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef TASK_PRIORITY_QUEUE_ASSERT_SVH
`define TASK_PRIORITY_QUEUE_ASSERT_SVH

// Check in the same cycle.
`define TPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check in the next cycle.
`define TPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tpq_pkg.sv
// Shared constants, types and helpers of the task priority queue.
// No dependencies.
package tpq_pkg;

    localparam int SLOTS       = 32;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int PRIO_LEVELS = 16;
    localparam int PRIO_W      = $clog2(PRIO_LEVELS);

    // Fixed field widths of the stream words.
    localparam int IN_PRIO_W  = 4;
    localparam int ID_W       = 32;
    localparam int ARG_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_SLOT_W = 5;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_DUP   = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_POP = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [PRIO_W-1:0] prio_t;

    // Entry payload held in the data RAM.
    typedef struct packed {
        prio_t            prio;
        logic [ID_W-1:0]  ident;
        logic [ARG_W-1:0] arg;
    } rec_t;

    // List link held in the link RAM.
    typedef struct packed {
        slot_t link;
        logic  valid;
    } lnk_t;

    typedef struct packed {
        logic  start;
        logic  set;
        slot_t set_idx;
        logic  clr;
        slot_t clr_idx;
    } fm_ctl_t;

    typedef struct packed {
        logic  done;
        logic  full;
        slot_t idx;
    } fm_stat_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

    // Clamp an incoming priority to the last level.
    function automatic prio_t sat_prio(logic [IN_PRIO_W-1:0] p);
        if (int'(p) >= PRIO_LEVELS) begin
            return PRIO_W'(PRIO_LEVELS - 1);
        end
        return PRIO_W'(p);
    endfunction

endpackage

>>> rtl/core/tpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/tpq_free_map.sv
// Slot-used bitmap with a one-bit-per-cycle scan for the lowest free slot.
// Depends on tpq_pkg.
module tpq_free_map
    import tpq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  fm_ctl_t  ctl,
    output fm_stat_t stat
);

    logic [SLOTS-1:0] used_reg;
    slot_t            scan_idx_reg;
    logic             scanning_reg;
    logic             done_reg;
    logic             full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            scan_idx_reg <= '0;
            scanning_reg <= 1'b0;
            done_reg     <= 1'b0;
            full_reg     <= 1'b0;
        end else begin
            if (ctl.set) begin
                used_reg[ctl.set_idx] <= 1'b1;
            end
            if (ctl.clr) begin
                used_reg[ctl.clr_idx] <= 1'b0;
            end
            if (ctl.start) begin
                scan_idx_reg <= '0;
                scanning_reg <= 1'b1;
                done_reg     <= 1'b0;
                full_reg     <= 1'b0;
            end else if (scanning_reg) begin
                if (!used_reg[scan_idx_reg]) begin
                    scanning_reg <= 1'b0;
                    done_reg     <= 1'b1;
                end else if (scan_idx_reg == SLOT_W'(SLOTS - 1)) begin
                    scanning_reg <= 1'b0;
                    done_reg     <= 1'b1;
                    full_reg     <= 1'b1;
                end else begin
                    scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.full = full_reg;
    assign stat.idx  = scan_idx_reg;

endmodule

>>> rtl/core/tpq_cmp.sv
// Compare unit: identity match and priority order of one entry.
// Depends on tpq_pkg.
module tpq_cmp
    import tpq_pkg::*;
(
    input  rec_t            rec,
    input  logic [ID_W-1:0] key_ident,
    input  prio_t           key_prio,
    output cmp_res_t        res
);

    assign res.eq = (rec.ident == key_ident);
    // Entry sorts after the new task: insertion point.
    assign res.gt = (rec.prio > key_prio);

endmodule

>>> rtl/core/task_priority_queue.sv
// Task priority queue: up to SLOTS tasks kept in one list sorted by priority.
//
// Input stream (s_*): one word per command. tuser[0] selects put (0) or pop (1),
// tuser[1] marks a real-time put. A put stores priority, identity and argument;
// a real-time put whose identity is already queued is skipped.
// Result stream (m_*): one word per command; tuser holds the status
// (ok, full, duplicate, empty), tdata the slot and, for a pop, the task.
// A pop takes the head entry in S_POP and registers its result in S_OUT. A put
// walks the list one entry per cycle through the link RAM while the free-slot
// scan checks one bitmap bit per cycle, each over up to SLOTS places; after the
// longer of the two it passes S_DECIDE, S_LINK when the task is stored behind a
// predecessor, and S_OUT. s_tready is high only between commands, so the next
// word is taken only after the last result has been registered. A finished
// result waits in the output register while m_tready is low; the next command is
// still taken, and its own result is held back until the waiting word has been
// handed over.
// Reset empties the queue at once; the entry RAMs need no clearing.
// Depends on tpq_pkg, tpq_ram, tpq_free_map, tpq_cmp and the assert header.
`include "task_priority_queue_assert.svh"

module task_priority_queue
    import tpq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // prio[3:0], task_id[35:4], task_arg[67:36], zero[71:68]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd[0], is_realtime[1]
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // slot[4:0], out_task_id[36:5], out_arg[68:37], out_prio[72:69], zero[79:73]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]    m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_DECIDE,
        S_LINK,
        S_OUT
    } state_t;

    state_t           state_reg;
    prio_t            prio_reg;
    logic [ID_W-1:0]  ident_reg;
    logic [ARG_W-1:0] arg_reg;
    logic             rt_reg;

    slot_t head_reg;
    logic  nonempty_reg;

    slot_t cur_reg;
    logic  walk_done_reg;
    logic  dup_reg;
    logic  found_reg;
    slot_t next_reg;
    slot_t pred_reg;
    logic  pred_valid_reg;
    slot_t new_slot_reg;

    status_t          res_status_reg;
    slot_t            res_slot_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic [ARG_W-1:0] res_arg_reg;
    prio_t            res_prio_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    status_t                m_tuser_reg;

    rec_t     rec_rd;
    rec_t     rec_wr;
    lnk_t     lnk_rd;
    lnk_t     lnk_wr;
    logic     rec_we;
    logic     lnk_we;
    slot_t    lnk_waddr;
    slot_t    rd_addr;
    cmp_res_t cmp;
    fm_ctl_t  fm_ctl;
    fm_stat_t fm_stat;
    logic     s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Read address: head on accept, follow the link while walking.
    always_comb begin
        unique case (state_reg)
            S_IDLE:  rd_addr = head_reg;
            S_WALK:  rd_addr = lnk_rd.link;
            default: rd_addr = cur_reg;
        endcase
    end

    always_comb begin
        rec_we       = 1'b0;
        lnk_we       = 1'b0;
        lnk_waddr    = fm_stat.idx;
        rec_wr.prio  = prio_reg;
        rec_wr.ident = ident_reg;
        rec_wr.arg   = arg_reg;
        lnk_wr.link  = next_reg;
        lnk_wr.valid = found_reg;
        if (state_reg == S_DECIDE && !(rt_reg && dup_reg) && !fm_stat.full) begin
            rec_we = 1'b1;
            lnk_we = 1'b1;
        end else if (state_reg == S_LINK) begin
            lnk_we       = 1'b1;
            lnk_waddr    = pred_reg;
            lnk_wr.link  = new_slot_reg;
            lnk_wr.valid = 1'b1;
        end
    end

    always_comb begin
        fm_ctl.start   = s_accept && (s_tuser[0] == CMD_PUT);
        fm_ctl.set     = rec_we;
        fm_ctl.set_idx = fm_stat.idx;
        fm_ctl.clr     = (state_reg == S_POP);
        fm_ctl.clr_idx = head_reg;
    end

    tpq_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (fm_stat.idx),
        .wdata (rec_wr),
        .raddr (rd_addr),
        .rdata (rec_rd)
    );

    tpq_ram #(
        .WIDTH ($bits(lnk_t)),
        .DEPTH (SLOTS)
    ) u_lnk_ram (
        .aclk  (aclk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wr),
        .raddr (rd_addr),
        .rdata (lnk_rd)
    );

    tpq_free_map u_free_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (fm_ctl),
        .stat    (fm_stat)
    );

    tpq_cmp u_cmp (
        .rec       (rec_rd),
        .key_ident (ident_reg),
        .key_prio  (prio_reg),
        .res       (cmp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            nonempty_reg   <= 1'b0;
            walk_done_reg  <= 1'b1;
            m_tvalid_reg   <= 1'b0;
            pred_valid_reg <= 1'b0;
            res_status_reg <= ST_OK;
        end else begin
            // Drop a taken word; S_OUT reloads the register on its own.
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        prio_reg       <= sat_prio(s_tdata[IN_PRIO_W-1:0]);
                        ident_reg      <= s_tdata[IN_PRIO_W +: ID_W];
                        arg_reg        <= s_tdata[IN_PRIO_W+ID_W +: ARG_W];
                        rt_reg         <= s_tuser[1];
                        cur_reg        <= head_reg;
                        walk_done_reg  <= !nonempty_reg;
                        dup_reg        <= 1'b0;
                        found_reg      <= 1'b0;
                        next_reg       <= '0;
                        pred_valid_reg <= 1'b0;
                        res_slot_reg   <= '0;
                        res_id_reg     <= '0;
                        res_arg_reg    <= '0;
                        res_prio_reg   <= '0;
                        if (s_tuser[0] == CMD_PUT) begin
                            state_reg <= S_WALK;
                        end else if (nonempty_reg) begin
                            state_reg <= S_POP;
                        end else begin
                            res_status_reg <= ST_EMPTY;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_POP: begin
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= head_reg;
                    res_id_reg     <= rec_rd.ident;
                    res_arg_reg    <= rec_rd.arg;
                    res_prio_reg   <= rec_rd.prio;
                    if (lnk_rd.valid) begin
                        head_reg <= lnk_rd.link;
                    end else begin
                        head_reg     <= '0;
                        nonempty_reg <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_WALK: begin
                    if (!walk_done_reg) begin
                        dup_reg <= dup_reg | cmp.eq;
                        if (!found_reg && cmp.gt) begin
                            found_reg <= 1'b1;
                            next_reg  <= cur_reg;
                        end else if (!found_reg) begin
                            pred_reg       <= cur_reg;
                            pred_valid_reg <= 1'b1;
                        end
                        if (lnk_rd.valid) begin
                            cur_reg <= lnk_rd.link;
                        end else begin
                            walk_done_reg <= 1'b1;
                        end
                    end else if (fm_stat.done) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    new_slot_reg <= fm_stat.idx;
                    priority if (rt_reg && dup_reg) begin
                        res_status_reg <= ST_DUP;
                        state_reg      <= S_OUT;
                    end else if (fm_stat.full) begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_OUT;
                    end else begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= fm_stat.idx;
                        if (pred_valid_reg) begin
                            state_reg <= S_LINK;
                        end else begin
                            // New task goes in front of the list.
                            head_reg     <= fm_stat.idx;
                            nonempty_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end
                    end
                end
                S_LINK: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {
                            (OUT_TDATA_W - OUT_SLOT_W - ID_W - ARG_W - IN_PRIO_W)'(0),
                            IN_PRIO_W'(res_prio_reg),
                            res_arg_reg,
                            res_id_reg,
                            OUT_SLOT_W'(res_slot_reg)
                        };
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TPQ_ASSERT_NOW(a_head_when_empty, !nonempty_reg, head_reg == '0, "head set on empty list")
    `TPQ_ASSERT_NEXT(a_pop_empty, s_accept && (s_tuser[0] == CMD_POP) && !nonempty_reg, res_status_reg == ST_EMPTY, "pop on empty not flagged")
    `TPQ_ASSERT_NOW(a_full_has_list, (state_reg == S_DECIDE) && fm_stat.full, nonempty_reg, "full map with empty list")
    `TPQ_ASSERT_NOW(a_link_has_pred, state_reg == S_LINK, pred_valid_reg, "link write without predecessor")

endmodule

>>> tb/task_priority_queue_tb.sv
// Self-checking testbench for task_priority_queue: put/pop words on the input stream,
// status and popped task checked against a behavioral model of the sorted slot list.
// Depends on tpq_pkg and the task_priority_queue RTL.
module task_priority_queue_tb;
    import tpq_pkg::*;

    localparam int RANDOM_ITEMS = 1760;
    localparam int ROUND_LEN    = 40;
    localparam int SETTLE_CYCLES = SLOTS + 10;

    typedef struct {
        status_t               status;
        logic [OUT_SLOT_W-1:0] slot;
        logic [ID_W-1:0]       ident;
        logic [ARG_W-1:0]      arg;
        logic [IN_PRIO_W-1:0]  prio;
    } result_t;

    typedef struct {
        int              slot;
        prio_t           prio;
        logic [ID_W-1:0] ident;
        logic [ARG_W-1:0] arg;
    } entry_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // prio[3:0], task_id[35:4], task_arg[67:36], zero[71:68]
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    // cmd[0], is_realtime[1]
    logic [1:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // slot[4:0], out_task_id[36:5], out_arg[68:37], out_prio[72:69], zero[79:73]
    logic [OUT_TDATA_W-1:0] m_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]    m_tuser;

    // Queued tasks in service order, and the slot occupancy bitmap.
    entry_t          ready_list[$];
    logic [SLOTS-1:0] slot_busy = '0;
    result_t         pending_results[$];
    int              mismatches = 0;
    bit              gap_en   = 1'b1;
    bit              stall_en = 1'b1;

    task_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Apply one command to the queue model and return the result it yields.
    function automatic result_t predict_command(logic cmd, logic [IN_PRIO_W-1:0] prio,
                                                logic [ID_W-1:0] ident, logic [ARG_W-1:0] arg,
                                                logic rt);
        result_t r;
        entry_t  e;
        int      free_idx;
        int      pos;
        bit      dup;
        r = '{status: ST_OK, slot: '0, ident: '0, arg: '0, prio: '0};
        free_idx = -1;
        pos = 0;
        dup = 1'b0;
        if (cmd == CMD_PUT) begin
            foreach (ready_list[i]) begin
                if (ready_list[i].ident == ident) dup = 1'b1;
            end
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!slot_busy[i]) free_idx = i;
            end
            if (rt && dup) begin
                r.status = ST_DUP;
            end else if (free_idx < 0) begin
                r.status = ST_FULL;
            end else begin
                e.slot  = free_idx;
                e.prio  = (int'(prio) >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1) : PRIO_W'(prio);
                e.ident = ident;
                e.arg   = arg;
                // land behind every entry of equal or better priority
                while (pos < ready_list.size() && ready_list[pos].prio <= e.prio) pos++;
                ready_list.insert(pos, e);
                slot_busy[free_idx] = 1'b1;
                r.slot = OUT_SLOT_W'(free_idx);
            end
        end else if (ready_list.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e = ready_list.pop_front();
            slot_busy[e.slot] = 1'b0;
            r.slot  = OUT_SLOT_W'(e.slot);
            r.ident = e.ident;
            r.arg   = e.arg;
            r.prio  = IN_PRIO_W'(e.prio);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_word(input logic cmd, input logic [IN_PRIO_W-1:0] prio,
                             input logic [ID_W-1:0] ident, input logic [ARG_W-1:0] arg,
                             input logic rt);
        int gap;
        gap = gap_en ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, arg, ident, prio};
        s_tuser  <= {rt, cmd};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_command(cmd, prio, ident, arg, rt));
    endtask

    // Result side: random stalls, then a run of ready cycles.
    initial begin
        int stall_len;
        @(posedge aresetn);
        forever begin
            stall_len = stall_en ? pick_gap() : 0;
            repeat (stall_len) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            repeat ($urandom_range(1, 12)) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, status", 32'(m_tuser), 32'hx);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[4:0] !== want.slot)
                    report_mismatch("slot", 32'(m_tdata[4:0]), 32'(want.slot));
                if (m_tdata[36:5] !== want.ident)
                    report_mismatch("out_task_id", m_tdata[36:5], want.ident);
                if (m_tdata[68:37] !== want.arg)
                    report_mismatch("out_arg", m_tdata[68:37], want.arg);
                if (m_tdata[72:69] !== want.prio)
                    report_mismatch("out_prio", 32'(m_tdata[72:69]), 32'(want.prio));
            end
        end
    end

    // Extremes, realtime skip, identity zero, FIFO ties, empty pops and slot reuse.
    task automatic test_directed_cases();
        send_word(CMD_POP, 4'hF, $urandom, $urandom, 1'b1);
        send_word(CMD_PUT, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(CMD_PUT, 4'h0, 32'h0, 32'h0, 1'b1);
        send_word(CMD_PUT, 4'h7, 32'h0, 32'h1111_2222, 1'b1);
        send_word(CMD_PUT, 4'h7, 32'h0, 32'h3333_4444, 1'b0);
        send_word(CMD_PUT, 4'h7, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0);
        send_word(CMD_PUT, 4'h0, 32'h1234_5678, 32'h8765_4321, 1'b1);
        send_word(CMD_PUT, 4'hF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        repeat (7) send_word(CMD_POP, 4'h0, $urandom, $urandom, 1'b0);
        // freed low slots must be taken again first
        send_word(CMD_PUT, 4'h3, 32'hCAFE_0001, 32'h1, 1'b0);
        send_word(CMD_PUT, 4'h3, 32'hCAFE_0002, 32'h2, 1'b0);
        send_word(CMD_POP, 4'h0, 32'h0, 32'h0, 1'b0);
        send_word(CMD_PUT, 4'h3, 32'hCAFE_0003, 32'h3, 1'b1);
        repeat (3) send_word(CMD_POP, 4'h0, 32'h0, 32'h0, 1'b0);
    endtask

    // Fill every slot, hit the full and the duplicate-when-full cases, drain.
    task automatic test_fill_to_full();
        logic [ID_W-1:0] first_id;
        first_id = $urandom;
        send_word(CMD_PUT, 4'($urandom), first_id, $urandom, 1'b0);
        repeat (SLOTS - 1) send_word(CMD_PUT, 4'($urandom), $urandom, $urandom, 1'($urandom));
        send_word(CMD_PUT, 4'h0, $urandom, $urandom, 1'b0);
        send_word(CMD_PUT, 4'h0, first_id, $urandom, 1'b1);
        send_word(CMD_PUT, 4'hF, $urandom, $urandom, 1'b1);
        repeat (SLOTS + 1) send_word(CMD_POP, 4'($urandom), $urandom, $urandom, 1'($urandom));
    endtask

    // Rounds of mixed traffic, each biased toward draining, balance or filling.
    task automatic test_random_traffic(input int count);
        logic [ID_W-1:0]      id_pool[8];
        logic [ID_W-1:0]      ident;
        logic [IN_PRIO_W-1:0] prio;
        logic                 cmd;
        int                   put_pct;
        int                   sent;
        foreach (id_pool[k]) id_pool[k] = $urandom;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 2))
                0: put_pct = 25;
                1: put_pct = 50;
                default: put_pct = 85;
            endcase
            gap_en   = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
            repeat (ROUND_LEN) begin
                cmd   = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_POP;
                prio  = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
                // reuse a few identities so the realtime skip fires
                ident = $urandom_range(0, 1) ? id_pool[$urandom_range(0, 7)] : $urandom;
                send_word(cmd, prio, ident, $urandom, 1'($urandom));
            end
            sent += ROUND_LEN;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_fill_to_full();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
